/* src/sss_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the sorted symbol set unit.
// Used by the channel interfaces, the top level and its checker.
package sss_pkg;

  localparam int unsigned SetDepth  = 64;
  localparam int unsigned CodeWidth = 8;
  localparam int unsigned IdxW      = $clog2(SetDepth);
  localparam int unsigned CntW      = IdxW + 1;

  // Fixed field widths of the channels.
  localparam int unsigned SymbolW   = 8;
  localparam int unsigned PositionW = 7;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_LOOKUP = 1'b1
  } mode_e;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_PLACE  = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

endpackage

/* src/sss_in_if.sv */
`timescale 1ns / 1ps
// Request channel of the sorted symbol set unit: operation and symbol code.
// Depends on sss_pkg.
interface sss_in_if import sss_pkg::*; ();
  logic                 valid;
  logic                 ready;
  mode_e                mode;
  logic [SymbolW-1:0]   symbol;

  modport source (output valid, output mode, output symbol, input ready);
  modport sink   (input valid, input mode, input symbol, output ready);
endinterface

/* src/sss_out_if.sv */
`timescale 1ns / 1ps
// Response channel of the sorted symbol set unit.
// Depends on sss_pkg.
interface sss_out_if import sss_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [PositionW-1:0] position;
  logic [PositionW-1:0] entry_count;
  logic                 overflow;

  modport source (output valid, output found, output position, output entry_count,
                  output overflow, input ready);
  modport sink   (input valid, input found, input position, input entry_count,
                  input overflow, output ready);
endinterface

/* src/sorted_symbol_set_unit.sv */
`timescale 1ns / 1ps
// Sorted symbol set: ascending set of distinct codes in a single-port-read RAM.
// Depends on sss_pkg, sss_in_if and sss_out_if.

// The unit handles one transaction at a time. A lookup runs a binary search
// over the entry RAM, one probe per cycle because the compare of one read
// selects the address of the next. An insert of a new code into a set that is
// not full then moves the entries above the insertion point up by one, one
// entry per cycle through the RAM's read and write ports, and writes the code;
// on a full set it is refused with the overflow flag. The next request is
// accepted once the current result is loaded into the output register, while
// that result may still wait to be taken. The entry RAM needs no clearing
// after reset.
module sorted_symbol_set_unit import sss_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  sss_in_if.sink        in_i,
  sss_out_if.source     out_o
);

  // Entry storage.
  logic [CodeWidth-1:0] mem [SetDepth];
  logic [CodeWidth-1:0] rdata_q;
  logic                 re;
  logic [IdxW-1:0]      raddr;
  logic                 we;
  logic [IdxW-1:0]      waddr;
  logic [CodeWidth-1:0] wdata;

  state_e               state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      lo_q, lo_d;
  logic [CntW-1:0]      hi_q, hi_d;
  logic [CntW-1:0]      mid_q, mid_d;
  logic                 fnd_q, fnd_d;
  logic                 pend_q, pend_d;
  logic                 ovf_q, ovf_d;
  mode_e                mode_q, mode_d;
  logic [CodeWidth-1:0] code_q, code_d;
  logic [CntW-1:0]      rem_q, rem_d;
  logic [IdxW-1:0]      ridx_q, ridx_d;
  logic [IdxW-1:0]      sh_waddr_q, sh_waddr_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_found_q, out_found_d;
  logic [CntW-1:0]      out_pos_q, out_pos_d;
  logic [CntW-1:0]      out_cnt_q, out_cnt_d;
  logic                 out_ovf_q, out_ovf_d;

  logic [CntW-1:0]      lo_c, hi_c, mid_c;
  logic                 fnd_c;

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.found       = out_found_q;
  assign out_o.position    = PositionW'(out_pos_q);
  assign out_o.entry_count = PositionW'(out_cnt_q);
  assign out_o.overflow    = out_ovf_q;

  // Search step: fold in the previous probe, then pick the next midpoint.
  always_comb begin
    lo_c  = lo_q;
    hi_c  = hi_q;
    fnd_c = fnd_q;
    if (pend_q) begin
      if (rdata_q < code_q) begin
        lo_c = mid_q + CntW'(1);
      end else begin
        hi_c  = mid_q;
        fnd_c = (rdata_q == code_q);
      end
    end
    mid_c = lo_c + ((hi_c - lo_c) >> 1);
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    fnd_d       = fnd_q;
    pend_d      = 1'b0;
    ovf_d       = ovf_q;
    mode_d      = mode_q;
    code_d      = code_q;
    rem_d       = rem_q;
    ridx_d      = ridx_q;
    sh_waddr_d  = sh_waddr_q;
    out_valid_d = out_valid_q;
    out_found_d = out_found_q;
    out_pos_d   = out_pos_q;
    out_cnt_d   = out_cnt_q;
    out_ovf_d   = out_ovf_q;
    re          = 1'b0;
    raddr       = mid_c[IdxW-1:0];
    we          = 1'b0;
    waddr       = sh_waddr_q;
    wdata       = rdata_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          mode_d  = in_i.mode;
          code_d  = in_i.symbol[CodeWidth-1:0];
          lo_d    = '0;
          hi_d    = count_q;
          fnd_d   = 1'b0;
          ovf_d   = 1'b0;
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        lo_d  = lo_c;
        hi_d  = hi_c;
        fnd_d = fnd_c;
        if (lo_c < hi_c) begin
          re     = 1'b1;
          mid_d  = mid_c;
          pend_d = 1'b1;
        end else if (mode_q == MODE_INSERT && !fnd_c) begin
          if (count_q == CntW'(SetDepth)) begin
            ovf_d   = 1'b1;
            state_d = S_FINISH;
          end else if (count_q > lo_c) begin
            rem_d   = count_q - lo_c;
            ridx_d  = IdxW'(count_q - CntW'(1));
            state_d = S_SHIFT;
          end else begin
            state_d = S_PLACE;
          end
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SHIFT: begin
        // Read entry ridx while the entry read last cycle lands one slot up.
        if (pend_q) begin
          we = 1'b1;
        end
        if (rem_q != '0) begin
          re         = 1'b1;
          raddr      = ridx_q;
          sh_waddr_d = ridx_q + IdxW'(1);
          ridx_d     = ridx_q - IdxW'(1);
          rem_d      = rem_q - CntW'(1);
          pend_d     = 1'b1;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        we      = 1'b1;
        waddr   = lo_q[IdxW-1:0];
        wdata   = code_q;
        count_d = count_q + CntW'(1);
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_found_d = fnd_q;
          out_pos_d   = lo_q;
          out_cnt_d   = count_q;
          out_ovf_d   = ovf_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    fnd_q       <= fnd_d;
    ovf_q       <= ovf_d;
    mode_q      <= mode_d;
    code_q      <= code_d;
    rem_q       <= rem_d;
    ridx_q      <= ridx_d;
    sh_waddr_q  <= sh_waddr_d;
    out_found_q <= out_found_d;
    out_pos_q   <= out_pos_d;
    out_cnt_q   <= out_cnt_d;
    out_ovf_q   <= out_ovf_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

endmodule

/* src/sss_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the sorted symbol set unit, bound to the top level.
// Depends on sss_pkg.
module sss_port_checker import sss_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic                 out_found_i,
  input logic [PositionW-1:0] out_position_i,
  input logic [PositionW-1:0] out_entry_count_i,
  input logic                 out_overflow_i
);

  // A result never reports more entries than the set holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_entry_count_i <= PositionW'(SetDepth)) &&
                    (out_position_i <= out_entry_count_i))
    else $error("position or entry count out of range");

  // A refused insert only happens on a full set and never for a present code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_overflow_i) |->
      (!out_found_i && out_entry_count_i == PositionW'(SetDepth)))
    else $error("overflow reported on a set that is not full");

  // The unit works on one transaction at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("request accepted while busy");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_found_i) && $stable(out_position_i) &&
       $stable(out_entry_count_i) && $stable(out_overflow_i)))
    else $error("stalled result changed");

endmodule

bind sorted_symbol_set_unit sss_port_checker u_sss_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_found_i       (out_o.found),
  .out_position_i    (out_o.position),
  .out_entry_count_i (out_o.entry_count),
  .out_overflow_i    (out_o.overflow)
);

/* bench/sss_checker.sv */
`timescale 1ns / 1ps
// Checker for the sorted symbol set unit: watches both channels, predicts each
// result from its own copy of the set, and counts mismatches. Depends on sss_pkg.
module sss_checker import sss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sss_in_if           req_ch,
  sss_out_if          rsp_ch,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic                 found;
    logic [PositionW-1:0] position;
    logic [PositionW-1:0] entry_count;
    logic                 overflow;
  } set_result_t;

  logic [CodeWidth-1:0] set_codes [SetDepth];
  int unsigned          set_count;
  set_result_t          expected_q [$];

  // Applies one operation to the mirrored set and returns the result it causes.
  function automatic set_result_t apply_set_op(input mode_e op,
                                               input logic [SymbolW-1:0] sym);
    logic [CodeWidth-1:0] code;
    int unsigned          lo;
    int unsigned          hi;
    int unsigned          mid;
    set_result_t          res;
    code = sym[CodeWidth-1:0];
    lo   = 0;
    hi   = set_count;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (set_codes[mid] < code) lo = mid + 1;
      else hi = mid;
    end
    // The entry at the count is never compared, so a code past the end is a miss.
    res.found    = (lo < set_count) && (set_codes[lo] == code);
    res.position = lo[PositionW-1:0];
    res.overflow = 1'b0;
    if (op == MODE_INSERT && !res.found) begin
      if (set_count >= SetDepth) begin
        res.overflow = 1'b1;
      end else begin
        for (int i = set_count; i > lo; i--) set_codes[i] = set_codes[i-1];
        set_codes[lo] = code;
        set_count++;
      end
    end
    res.entry_count = set_count[PositionW-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    set_result_t exp_res;
    set_result_t act_res;
    if (!rst_ni) begin
      set_count = 0;
      expected_q.delete();
      mismatch_cnt_o = 0;
      pending_o = 0;
    end else begin
      // Results belong to older requests, so they are retired first.
      if (rsp_ch.valid && rsp_ch.ready) begin
        act_res = '{rsp_ch.found, rsp_ch.position, rsp_ch.entry_count, rsp_ch.overflow};
        if (expected_q.size() == 0) begin
          mismatch_cnt_o++;
          if (mismatch_cnt_o <= 10)
            $display("%0t: result with nothing expected: found=%0b pos=%0d cnt=%0d ovf=%0b",
                     $realtime, act_res.found, act_res.position, act_res.entry_count,
                     act_res.overflow);
        end else begin
          exp_res = expected_q.pop_front();
          if (act_res !== exp_res) begin
            mismatch_cnt_o++;
            if (mismatch_cnt_o <= 10)
              $display("%0t: mismatch exp found=%0b pos=%0d cnt=%0d ovf=%0b, got found=%0b pos=%0d cnt=%0d ovf=%0b",
                       $realtime, exp_res.found, exp_res.position, exp_res.entry_count,
                       exp_res.overflow, act_res.found, act_res.position,
                       act_res.entry_count, act_res.overflow);
          end
        end
      end
      if (req_ch.valid && req_ch.ready)
        expected_q.push_back(apply_set_op(req_ch.mode, req_ch.symbol));
      pending_o = expected_q.size();
    end
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Top of the sorted symbol set unit testbench: clock, reset, request and
// response traffic, and the verdict. Depends on sss_pkg, the channel interfaces and sss_checker.
module tb_top;
  import sss_pkg::*;

  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned RandomItems = 1200;
  localparam int unsigned DrainCycles = 100;

  logic        clk_i;
  logic        rst_ni;
  bit          src_idle_en;
  bit          snk_idle_en;
  int unsigned mismatch_cnt;
  int unsigned pending;

  sss_in_if  req_ch ();
  sss_out_if rsp_ch ();

  sorted_symbol_set_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (rsp_ch)
  );

  sss_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_ch         (req_ch),
    .rsp_ch         (rsp_ch),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= snk_idle_en ? ($urandom_range(99) >= 17) : 1'b1;
    end
  end

  task automatic send_op(input mode_e op, input logic [SymbolW-1:0] sym);
    while (src_idle_en && $urandom_range(99) < 17) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid  <= 1'b1;
    req_ch.mode   <= op;
    req_ch.symbol <= sym;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Holds off new requests until every outstanding result has been taken.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("** sorted_symbol_set_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [SymbolW-1:0] inserted_codes [$];
    logic [SymbolW-1:0] sym;
    mode_e              op;
    int unsigned        insert_pct;
    int unsigned        pick;

    rst_ni        = 1'b0;
    req_ch.valid  = 1'b0;
    req_ch.mode   = MODE_INSERT;
    req_ch.symbol = '0;
    src_idle_en   = 1'b1;
    snk_idle_en   = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: lookups on the empty set, both ends of the code range,
    // duplicates, and misses just inside both ends of the stored codes.
    send_op(MODE_LOOKUP, 8'h00);
    send_op(MODE_LOOKUP, 8'hFF);
    send_op(MODE_INSERT, 8'h80);
    send_op(MODE_INSERT, 8'h80);
    send_op(MODE_INSERT, 8'h00);
    send_op(MODE_INSERT, 8'hFF);
    send_op(MODE_INSERT, 8'h7F);
    send_op(MODE_INSERT, 8'h81);
    send_op(MODE_LOOKUP, 8'h00);
    send_op(MODE_LOOKUP, 8'hFF);
    send_op(MODE_LOOKUP, 8'h80);
    send_op(MODE_LOOKUP, 8'h01);
    send_op(MODE_LOOKUP, 8'hFE);
    send_op(MODE_INSERT, 8'h55);
    send_op(MODE_INSERT, 8'hAA);
    send_op(MODE_INSERT, 8'h00);
    send_op(MODE_LOOKUP, 8'h55);
    send_op(MODE_LOOKUP, 8'hAA);
    inserted_codes = '{8'h80, 8'h00, 8'hFF, 8'h7F, 8'h81, 8'h55, 8'hAA};
    drain_results();

    // Random: the set fills slowly at first so that every fill level sees
    // traffic, then fills up and stays full, where inserts overflow.
    for (int n = 0; n < RandomItems; n++) begin
      src_idle_en = !(n >= 400 && n < 650);
      snk_idle_en = src_idle_en;
      if (n == 600) drain_results();
      insert_pct = (n < 500) ? 12 : 40;
      op   = ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_LOOKUP;
      pick = $urandom_range(99);
      if (pick < 40) begin
        sym = inserted_codes[$urandom_range(inserted_codes.size() - 1)];
      end else if (pick < 60) begin
        sym = inserted_codes[$urandom_range(inserted_codes.size() - 1)];
        sym = $urandom_range(1) ? sym + 8'd1 : sym - 8'd1;
      end else begin
        sym = SymbolW'($urandom_range(255));
      end
      send_op(op, sym);
      if (op == MODE_INSERT) inserted_codes.push_back(sym);
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("** sorted_symbol_set_unit: PASSED **");
    end else begin
      $display("** sorted_symbol_set_unit: FAILED **");
    end
    $finish;
  end

endmodule
